FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the accumulator display block.
// No dependencies; the including module supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define SAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define SAT_ASSERT_NEVER(label, cond, msg) \
  `SAT_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/core/satacc_pkg.sv
// Shared types, constants and the segment table of the accumulator display block.
// No dependencies.
package satacc_pkg;

  localparam int unsigned SW_W    = 10;  // switch operand width
  localparam int unsigned EDGE_W  = 4;   // captured key edge word width
  localparam int unsigned SEG_W   = 8;   // one digit of segment code
  localparam int unsigned DIGITS  = 4;
  localparam int unsigned WORD_W  = SEG_W * DIGITS;
  localparam int unsigned DIGIT_W = 4;

  // Key edge bit positions.
  localparam int unsigned EDGE_ADD_BIT = 0;
  localparam int unsigned EDGE_SUB_BIT = 1;
  localparam int unsigned EDGE_CLR_BIT = 2;

  // Binary to decimal conversion works on values of up to 13 bits (8191).
  localparam int unsigned BIN_W      = 13;
  localparam int unsigned RECIP_W    = 15;
  localparam int unsigned PROD_W     = BIN_W + RECIP_W;
  localparam int unsigned SHIFT_10   = 16;
  localparam int unsigned SHIFT_100  = 20;
  localparam int unsigned SHIFT_1000 = 24;
  localparam logic [RECIP_W-1:0] RECIP_10   = 15'd6554;   // 2^16 / 10, rounded up
  localparam logic [RECIP_W-1:0] RECIP_100  = 15'd10486;  // 2^20 / 100, rounded up
  localparam logic [RECIP_W-1:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000, rounded up

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_ZERO  = 8'h3F;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;

  // Active-high gfedcba code for one decimal digit.
  function automatic seg_t seg_code(input digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/satacc_seg_enc.sv
// Binary to four-digit seven-segment encoder with leading-zero blanking.
// Depends on satacc_pkg.
module satacc_seg_enc #(
  parameter int unsigned VAL_WIDTH = 10
) (
  input  logic [VAL_WIDTH-1:0]            val_i,
  output logic [satacc_pkg::WORD_W-1:0]   word_o
);
  import satacc_pkg::*;

  logic [BIN_W-1:0]  v;
  logic [PROD_W-1:0] prod10, prod100, prod1000;
  logic [BIN_W-1:0]  q1, q2, q3;
  logic [BIN_W-1:0]  r0, r1, r2;

  // Quotients by 10, 100 and 1000 come from reciprocal multiplies, exact below 8192.
  always_comb begin
    v        = BIN_W'(val_i);
    prod10   = PROD_W'(v) * PROD_W'(RECIP_10);
    prod100  = PROD_W'(v) * PROD_W'(RECIP_100);
    prod1000 = PROD_W'(v) * PROD_W'(RECIP_1000);
    q1       = BIN_W'(prod10   >> SHIFT_10);
    q2       = BIN_W'(prod100  >> SHIFT_100);
    q3       = BIN_W'(prod1000 >> SHIFT_1000);
    r0       = v  - ((q1 << 3) + (q1 << 1));
    r1       = q1 - ((q2 << 3) + (q2 << 1));
    r2       = q2 - ((q3 << 3) + (q3 << 1));
  end

  assign word_o[SEG_W-1:0]         = seg_code(r0[DIGIT_W-1:0]);
  assign word_o[2*SEG_W-1:SEG_W]   = (q1 != '0) ? seg_code(r1[DIGIT_W-1:0]) : SEG_BLANK;
  assign word_o[3*SEG_W-1:2*SEG_W] = (q2 != '0) ? seg_code(r2[DIGIT_W-1:0]) : SEG_BLANK;
  assign word_o[4*SEG_W-1:3*SEG_W] = (q3 != '0) ? seg_code(q3[DIGIT_W-1:0]) : SEG_BLANK;

endmodule

FILE: rtl/core/saturating_accumulator_bcd_display_top.sv
// Top level of the saturating accumulator with a four-digit segment display.
// Depends on satacc_pkg, satacc_seg_enc and assert_macros.svh.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  input   | in_valid_i / in_stall_o | key_edges_i, switch_value_i
//  output  | out_valid_o/ out_stall_i| changed_o, accumulator_out_o, display_word_o
//
// One item per cycle is sustained while the output does not stall; a result passes
// through all three registers before it is presented on the output channel.
// The three registers are the input register, the accumulator update and the display encoder.
// Reset clears the accumulator, the held display word and all stage valid bits.
// A stall on the output holds every full stage with no empty stage after it; an empty stage still takes a new item.
`include "assert_macros.svh"

module saturating_accumulator_bcd_display_top #(
  parameter int unsigned ACC_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [satacc_pkg::EDGE_W-1:0] key_edges_i,
  input  logic [satacc_pkg::SW_W-1:0]   switch_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          changed_o,
  output logic [ACC_WIDTH-1:0]          accumulator_out_o,
  output logic [satacc_pkg::WORD_W-1:0] display_word_o
);
  import satacc_pkg::*;

  // The sum needs one bit above the wider of accumulator and operand.
  localparam int unsigned SUM_W = ((ACC_WIDTH > SW_W) ? ACC_WIDTH : SW_W) + 1;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  // Stage ready chain: a stage moves on when it is empty or the next one moves.
  logic out_ready, mid_ready, in_ready;
  logic in_adv, mid_adv;

  // Input register.
  logic              in_valid_q;
  logic [EDGE_W-1:0] in_edges_q;
  logic [SW_W-1:0]   in_sw_q;

  // Accumulator and the snapshot handed to the encoder stage.
  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                 mid_valid_q;
  logic                 mid_changed_q;
  logic [ACC_WIDTH-1:0] mid_acc_q;

  // Result register; disp_q doubles as the held display word.
  logic                 out_valid_q;
  logic                 out_changed_q;
  logic [ACC_WIDTH-1:0] out_acc_q;
  logic [WORD_W-1:0]    disp_q;
  logic [WORD_W-1:0]    enc_word;

  logic [SUM_W-1:0] old_ext, sw_ext, sum;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign mid_ready = !mid_valid_q || out_ready;
  assign in_ready  = !in_valid_q || mid_ready;
  assign in_adv    = in_valid_q && mid_ready;
  assign mid_adv   = mid_valid_q && out_ready;

  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_edges_q <= key_edges_i;
      in_sw_q    <= switch_value_i;
    end
  end

  // Every rule works from the accumulator value held before the item.
  // Clear wins over subtract, and subtract wins over add.
  always_comb begin
    old_ext = SUM_W'(acc_q);
    sw_ext  = SUM_W'(in_sw_q);
    sum     = old_ext + sw_ext;
    acc_d   = acc_q;
    priority if (in_edges_q[EDGE_CLR_BIT]) begin
      acc_d = '0;
    end else if (in_edges_q[EDGE_SUB_BIT]) begin
      acc_d = (sw_ext > old_ext) ? '0 : ACC_WIDTH'(old_ext - sw_ext);
    end else if (in_edges_q[EDGE_ADD_BIT]) begin
      acc_d = (sum >= SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_WIDTH'(sum);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      mid_valid_q <= 1'b0;
    end else begin
      if (mid_ready) begin
        mid_valid_q <= in_valid_q;
      end
      // An item with no edge bit set leaves the accumulator alone.
      if (in_adv && (in_edges_q != '0)) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      mid_changed_q <= (in_edges_q != '0);
      mid_acc_q     <= (in_edges_q != '0) ? acc_d : acc_q;
    end
  end

  satacc_seg_enc #(
    .VAL_WIDTH (ACC_WIDTH)
  ) u_seg_enc (
    .val_i  (mid_acc_q),
    .word_o (enc_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      disp_q      <= '0;
    end else begin
      if (out_ready) begin
        out_valid_q <= mid_valid_q;
      end
      // The display is rebuilt only for a changing item and held otherwise.
      if (mid_adv && mid_changed_q) begin
        disp_q <= enc_word;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_adv) begin
      out_changed_q <= mid_changed_q;
      out_acc_q     <= mid_acc_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign changed_o         = out_changed_q;
  assign accumulator_out_o = out_acc_q;
  assign display_word_o    = disp_q;

  // An item without edge bits must not move the accumulator.
  `SAT_ASSERT(a_no_edge_hold, (in_adv && (in_edges_q == '0)) |=> (acc_q == $past(acc_q)),
              "accumulator moved on an item without edges")

  // A clear edge always empties the accumulator.
  `SAT_ASSERT(a_clear_zero, (in_adv && in_edges_q[EDGE_CLR_BIT]) |=> (acc_q == '0),
              "clear edge did not empty the accumulator")

  // A changed result of zero shows a single zero digit and nothing else.
  `SAT_ASSERT(a_zero_display,
              (out_valid_o && changed_o && (accumulator_out_o == '0)) |->
              (display_word_o == {{(WORD_W-SEG_W){1'b0}}, SEG_ZERO}),
              "zero value shown with wrong segments")

  // The encoder stage never holds an unchanged item whose value differs from a changed result in the output register.
  `SAT_ASSERT_NEVER(a_mid_snapshot,
                    mid_valid_q && !mid_changed_q && out_valid_q && out_changed_q &&
                    (mid_acc_q != out_acc_q),
                    "unchanged item carries a stale accumulator")

endmodule

FILE: tb/sv/accumulator_display_checker.sv
`timescale 1ns / 1ps
// Checker for the saturating accumulator display block: it watches both channels,
// predicts each result from the accepted inputs and compares. Depends on satacc_pkg.
module accumulator_display_checker #(
  parameter int unsigned ACC_WIDTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [satacc_pkg::EDGE_W-1:0] key_edges_i,
  input  logic [satacc_pkg::SW_W-1:0]   switch_value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          changed_i,
  input  logic [ACC_WIDTH-1:0]          accumulator_i,
  input  logic [satacc_pkg::WORD_W-1:0] display_word_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o,
  output int unsigned                   clamps_o
);
  import satacc_pkg::*;

  localparam int unsigned LEVEL_MAX = (1 << ACC_WIDTH) - 1;
  localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  typedef struct packed {
    logic                 changed;
    logic [ACC_WIDTH-1:0] level;
    logic [WORD_W-1:0]    segments;
  } readout_t;

  readout_t          readout_q[$];
  int unsigned       level;
  logic [WORD_W-1:0] shown_word;
  int unsigned       mismatches;
  int unsigned       results;
  int unsigned       clamps;

  // A digit is lit when the value reaches its decade; digit 0 is always lit.
  function automatic logic [WORD_W-1:0] decimal_segments(input int unsigned value);
    logic [WORD_W-1:0] word;
    int unsigned       rest;
    word = '0;
    rest = value;
    for (int d = 0; d < DIGITS; d++) begin
      if (d == 0 || rest != 0) word[d*SEG_W +: SEG_W] = DIGIT_SEGMENTS[rest % 10];
      rest = rest / 10;
    end
    return word;
  endfunction

  task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t    want;
    int unsigned operand;
    int unsigned next;
    if (!rst_ni) begin
      readout_q.delete();
      level      = 0;
      shown_word = '0;
      mismatches = 0;
      results    = 0;
      clamps     = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        operand = switch_value_i;
        next    = level;
        if (key_edges_i != '0) begin
          // Later rules override earlier ones; all of them start from the old level.
          if (key_edges_i[EDGE_ADD_BIT]) next = (level + operand >= LEVEL_MAX) ?
                                                LEVEL_MAX : level + operand;
          if (key_edges_i[EDGE_SUB_BIT]) next = (operand > level) ? 0 : level - operand;
          if (key_edges_i[EDGE_CLR_BIT]) next = 0;
          if (!key_edges_i[EDGE_CLR_BIT] &&
              (key_edges_i[EDGE_SUB_BIT] ? operand > level : key_edges_i[EDGE_ADD_BIT] &&
               level + operand > LEVEL_MAX)) clamps++;
          level      = next;
          shown_word = decimal_segments(level);
        end
        want.changed  = (key_edges_i != '0);
        want.level    = level[ACC_WIDTH-1:0];
        want.segments = shown_word;
        readout_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (readout_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0b/%0d/0x%0h", $time,
                   changed_i, accumulator_i, display_word_i);
          mismatches++;
        end else begin
          want = readout_q.pop_front();
          if (changed_i !== want.changed) report_field("changed", want.changed, changed_i);
          if (accumulator_i !== want.level)
            report_field("accumulator_out", want.level, accumulator_i);
          if (display_word_i !== want.segments)
            report_field("display_word", want.segments, display_word_i);
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= readout_q.size();
    results_o    <= results;
    clamps_o     <= clamps;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for the saturating accumulator display block: clock, reset,
// stimulus, receiver stalls and verdict. Depends on satacc_pkg and the checker module.
module testbench;
  import satacc_pkg::*;

  localparam int unsigned ACC_BITS     = 10;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned DRAIN_LIMIT  = 4000;

  typedef logic [EDGE_W-1:0] keys_t;
  typedef logic [SW_W-1:0]   operand_t;

  // Key edge words, built from the bit positions of the package.
  localparam keys_t KEY_NONE  = '0;
  localparam keys_t KEY_ADD   = keys_t'(1 << EDGE_ADD_BIT);
  localparam keys_t KEY_SUB   = keys_t'(1 << EDGE_SUB_BIT);
  localparam keys_t KEY_CLR   = keys_t'(1 << EDGE_CLR_BIT);
  localparam keys_t KEY_SPARE = keys_t'(1 << (EDGE_W - 1));
  localparam keys_t KEY_ALL   = '1;
  localparam operand_t OPERAND_MAX = '1;

  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  keys_t                key_edges_i    = '0;
  operand_t             switch_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 changed_o;
  logic [ACC_BITS-1:0]  accumulator_out_o;
  logic [WORD_W-1:0]    display_word_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned clamp_count;

  int unsigned burst_left = 0;
  int unsigned transfers  = 0;
  int unsigned quiet_keys = 0;
  int unsigned stall_tick = 0;

  saturating_accumulator_bcd_display_top #(
    .ACC_WIDTH(ACC_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .key_edges_i      (key_edges_i),
    .switch_value_i   (switch_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .changed_o        (changed_o),
    .accumulator_out_o(accumulator_out_o),
    .display_word_o   (display_word_o)
  );

  accumulator_display_checker #(
    .ACC_WIDTH(ACC_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .key_edges_i   (key_edges_i),
    .switch_value_i(switch_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .changed_i     (changed_o),
    .accumulator_i (accumulator_out_o),
    .display_word_i(display_word_o),
    .mismatches_o  (mismatch_count),
    .pending_o     (pending_count),
    .results_o     (result_count),
    .clamps_o      (clamp_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // This bound lies well beyond the slowest correct run, so it only
  // catches a block that stops moving transfers.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // The receiver cycles through four stall behaviors in equal turns: never
  // stalling, light random stalls, heavy random stalls and a fixed repeating
  // pattern of stalls.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      case ((stall_tick / 512) % 4)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_tick % 8 < 5);
      endcase
    end
  end

  // Offers one item and returns at the edge where it is accepted. The sender
  // works in bursts; between bursts it usually drops valid and drives junk on
  // the payload, which the block must ignore.
  task automatic send_item(input keys_t keys, input operand_t value);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i     <= 1'b0;
        key_edges_i    <= keys_t'($urandom);
        switch_value_i <= operand_t'($urandom);
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    key_edges_i    <= keys;
    switch_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    transfers++;
    if (keys == KEY_NONE) quiet_keys++;
  endtask

  // Holds the sender off until every outstanding result has been transferred
  // or the limit runs out. The count is checked only after an edge, as the checker's count is registered.
  task automatic wait_for_idle(input int unsigned limit);
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_count != 0 && waited < limit);
  endtask

  // Random key words lean toward one direction so that runs of adds reach the
  // upper bound and runs of subtracts reach zero; the rest is noise.
  function automatic keys_t pick_keys(input bit climbing);
    int unsigned roll;
    keys_t       spare;
    roll  = $urandom_range(0, 99);
    spare = ($urandom_range(0, 7) == 0) ? KEY_SPARE : KEY_NONE;
    if (roll < 12) return KEY_NONE;
    if (roll < 22) return keys_t'($urandom_range(0, 15));
    if (roll < 25) return KEY_CLR | spare;
    if (roll < 70) return (climbing ? KEY_ADD : KEY_SUB) | spare;
    return (climbing ? KEY_SUB : KEY_ADD) | spare;
  endfunction

  function automatic operand_t pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)  return '0;
    if (roll < 16) return OPERAND_MAX;
    if (roll < 55) return operand_t'($urandom_range(0, 31));
    if (roll < 80) return operand_t'($urandom_range(0, 255));
    return operand_t'($urandom);
  endfunction

  initial begin
    bit climbing;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. No edge right after reset must repeat the blank display,
    // and the spare bit alone still counts as a change and shows a lone zero.
    send_item(KEY_NONE, OPERAND_MAX);
    send_item(KEY_SPARE, '0);
    send_item(KEY_ADD, '0);
    // Saturation at the top, then a further add that stays clamped.
    send_item(KEY_ADD, OPERAND_MAX);
    send_item(KEY_ADD, 10'd5);
    send_item(KEY_NONE, 10'd77);
    // Walk down through four, three, two and one digit values.
    send_item(KEY_SUB, 10'd23);
    send_item(KEY_SUB, 10'd1);
    send_item(KEY_SUB, 10'd900);
    send_item(KEY_SUB, 10'd90);
    send_item(KEY_ADD, 10'd1);
    // Subtract larger than the level clamps at zero.
    send_item(KEY_SUB, OPERAND_MAX);
    // Subtract overrides add; clear overrides both.
    send_item(KEY_ADD, 10'd500);
    send_item(KEY_ADD | KEY_SUB, 10'd100);
    send_item(KEY_ADD | KEY_SUB | KEY_CLR, 10'd3);
    // Reaching the maximum exactly, then subtracting all of it.
    send_item(KEY_ADD, 10'd1022);
    send_item(KEY_ADD, 10'd1);
    send_item(KEY_SUB, OPERAND_MAX);
    send_item(KEY_ADD | KEY_SPARE, 10'd8);
    send_item(KEY_CLR, 10'd341);
    send_item(KEY_ADD, 10'd682);
    send_item(KEY_ALL, 10'd682);
    send_item(KEY_NONE, '0);
    wait_for_idle(DRAIN_LIMIT);
    burst_left = 0;

    // Random part, with one more hold-off halfway through.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) climbing = $urandom_range(0, 1);
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_idle(DRAIN_LIMIT);
        burst_left = 0;
      end
      send_item(pick_keys(climbing), pick_operand());
    end

    wait_for_idle(DRAIN_LIMIT);
    repeat (8) @(posedge clk_i);
    if (pending_count != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_count);

    $display("Run covered %0d input transfers (%0d without a key edge), %0d results checked.",
             transfers, quiet_keys, result_count);
    $display("The accumulator was clamped at a bound %0d times.", clamp_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
